FILE: rtl/sst_pkg.sv
// swap slot table package: operation and status codes, result record
// no dependencies; used by sst_tag_ram, sst_engine and swap_slot_table_top
package sst_pkg;

    localparam int PAGE_W      = 20;
    localparam int SLOT_OUT_W  = 4;
    localparam int COUNT_OUT_W = 5;
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 16;

    typedef enum logic [1:0] {
        OP_SWAP_OUT = 2'd0,
        OP_SWAP_IN  = 2'd1,
        OP_QUERY    = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_NO_FRAME  = 3'd4
    } t_status;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] slots_in_use;
        logic                   page_present;
        logic [SLOT_OUT_W-1:0]  slot_index;
        t_status                status;
    } t_result;

endpackage

FILE: rtl/sst_tag_ram.sv
// page tag storage: one write port, one read port, registered read data
// depends on sst_pkg for the tag width
module sst_tag_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [sst_pkg::PAGE_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [sst_pkg::PAGE_W-1:0] o_rd_data
);

    logic [sst_pkg::PAGE_W-1:0] r_mem [DEPTH];
    logic [sst_pkg::PAGE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/sst_engine.sv
// slot walk sequencer: walks the tag ram one slot per cycle, tracks first
// hit and first free slot, then commits valid bits, count and tag write
// depends on sst_pkg and sst_tag_ram
module sst_engine #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_enabled,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  sst_pkg::t_op               i_operation,
    input  logic [sst_pkg::PAGE_W-1:0] i_page_number,
    input  logic                       i_frame_granted,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output sst_pkg::t_result           o_res
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] SLOT_CNT  = CW'(SLOT_COUNT);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                     r_state;
    logic [CW-1:0]              r_rd_cnt;
    logic                       r_cmp_v;
    logic [IW-1:0]              r_cmp_idx;
    logic                       r_cmp_vbit;
    logic                       r_hit;
    logic [IW-1:0]              r_hit_idx;
    logic                       r_free;
    logic [IW-1:0]              r_free_idx;
    sst_pkg::t_op               r_op;
    logic [sst_pkg::PAGE_W-1:0] r_page;
    logic                       r_frame;
    logic [SLOT_COUNT-1:0]      r_valid;
    logic [CW-1:0]              r_count;

    logic [SLOT_COUNT-1:0]      n_valid;
    logic [CW-1:0]              n_count;
    logic                       accept;
    logic                       issue;
    logic                       commit;
    logic                       walk_end;
    logic                       cmp_hit;
    logic [IW-1:0]              rd_addr;
    logic [sst_pkg::PAGE_W-1:0] rd_tag;
    logic                       mem_we;
    sst_pkg::t_status           status;
    logic [IW-1:0]              slot;

    assign o_in_ready = r_state == S_IDLE;
    assign accept     = i_in_valid && o_in_ready;
    assign issue      = (r_state == S_WALK) && (r_rd_cnt != SLOT_CNT);
    assign rd_addr    = r_rd_cnt[IW-1:0];
    assign cmp_hit    = r_cmp_v && r_cmp_vbit && (rd_tag == r_page);
    assign walk_end   = r_cmp_v && (r_cmp_idx == LAST_IDX);
    assign o_res_valid = r_state == S_DONE;
    assign commit     = o_res_valid && i_res_ready;

    sst_tag_ram #(
        .DEPTH (SLOT_COUNT),
        .AW    (IW)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_free_idx),
        .i_wr_data (r_page),
        .i_rd_en   (issue),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_tag)
    );

    // outcome of the finished walk, or of a clear
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        mem_we  = 1'b0;
        status  = sst_pkg::ST_OK;
        slot    = '0;
        case (r_op)
            sst_pkg::OP_SWAP_OUT: begin
                if (!i_enabled) begin
                    status = sst_pkg::ST_NOT_READY;
                end else if (r_hit) begin
                    slot = r_hit_idx;
                end else if (!r_free) begin
                    status = sst_pkg::ST_FULL;
                end else begin
                    slot                = r_free_idx;
                    n_valid[r_free_idx] = 1'b1;
                    n_count             = r_count + CW'(1);
                    mem_we              = commit;
                end
            end
            sst_pkg::OP_SWAP_IN: begin
                if (!i_enabled) begin
                    status = sst_pkg::ST_NOT_READY;
                end else if (!r_hit) begin
                    status = sst_pkg::ST_NOT_FOUND;
                end else begin
                    slot = r_hit_idx;
                    if (!r_frame) begin
                        status = sst_pkg::ST_NO_FRAME;
                    end else begin
                        n_valid[r_hit_idx] = 1'b0;
                        if (r_count != '0) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
            end
            sst_pkg::OP_QUERY: begin
                if (r_hit) begin
                    slot = r_hit_idx;
                end
            end
            default: begin
                n_valid = '0;
                n_count = '0;
            end
        endcase
    end

    assign o_res.status       = status;
    assign o_res.slot_index   = sst_pkg::SLOT_OUT_W'(slot);
    assign o_res.page_present = r_hit;
    assign o_res.slots_in_use = sst_pkg::COUNT_OUT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmp_v <= 1'b0;
            r_valid <= '0;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cmp_v <= 1'b0;
                    if (accept) begin
                        r_state <= (i_operation == sst_pkg::OP_CLEAR) ? S_DONE : S_WALK;
                    end
                end
                S_WALK: begin
                    r_cmp_v <= issue;
                    if (walk_end) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_cmp_v <= 1'b0;
                    if (commit) begin
                        r_valid <= n_valid;
                        r_count <= n_count;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_operation;
            r_page   <= i_page_number;
            r_frame  <= i_frame_granted;
            r_rd_cnt <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else begin
            if (issue) begin
                r_rd_cnt <= r_rd_cnt + CW'(1);
            end
            if (cmp_hit && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
            end
            if (r_cmp_v && !r_cmp_vbit && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
        end
        r_cmp_idx  <= rd_addr;
        r_cmp_vbit <= r_valid[rd_addr];
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOT_CNT)
        else $error("slot count out of range");

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'($countones(r_valid)) == r_count)
        else $error("slot count differs from occupied slots");

    a_write_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !r_valid[r_free_idx])
        else $error("tag write into occupied slot");

    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_state == S_IDLE)
        else $error("sequencer not idle after commit");

endmodule

FILE: rtl/swap_slot_table_top.sv
// Swap slot table. Each transaction walks the whole tag ram, one slot read
// per cycle. Swap-out, swap-in and query go from acceptance through a walk
// of SLOT_COUNT slot reads, each compared once its ram read data is
// registered, to a commit into the output register. A clear skips the walk.
// The walk is paced by the single tag ram read port. The output register
// holds a finished result while the next transaction is accepted and walked.
// Valid bits and the slot count are flops cleared by reset; the tag ram
// needs no clearing pass.
// depends on sst_pkg and sst_engine
module swap_slot_table_top #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [sst_pkg::S_TDATA_W-1:0] i_s_tdata,  // page_number, frame_granted
    input  logic [sst_pkg::S_TUSER_W-1:0] i_s_tuser,  // operation
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [sst_pkg::M_TDATA_W-1:0] o_m_tdata   // status, slot_index,
                                                      // page_present, slots_in_use
);

    logic             r_enabled;
    logic             r_out_valid;
    sst_pkg::t_result r_out;

    logic             res_valid;
    logic             res_ready;
    sst_pkg::t_result res;

    assign res_ready = !r_out_valid || i_m_tready;

    sst_engine #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_enabled       (r_enabled),
        .i_in_valid      (i_s_tvalid),
        .o_in_ready      (o_s_tready),
        .i_operation     (sst_pkg::t_op'(i_s_tuser)),
        .i_page_number   (i_s_tdata[sst_pkg::PAGE_W-1:0]),
        .i_frame_granted (i_s_tdata[sst_pkg::PAGE_W]),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_res           (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enabled <= i_cfg_wdata;
            end
            if (res_ready) begin
                r_out_valid <= res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = sst_pkg::M_TDATA_W'(r_out);

endmodule

FILE: dv/sst_checker.sv
`timescale 1ns / 100ps
// reply checker for swap_slot_table_top: tracks the enable register and the slot table
// from the request channel and compares every reply field; depends on sst_pkg
module sst_checker
    import sst_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_full_hits
);

    logic [PAGE_W-1:0]      slot_page [SLOT_COUNT];
    logic                   slot_live [SLOT_COUNT];
    logic [COUNT_OUT_W-1:0] occupancy = '0;
    logic                   store_ready = 1'b0;
    t_result                awaited_replies [$];
    int                     mismatches = 0;
    int                     full_hits = 0;

    // applies one request to the table copy and returns the reply it earns
    function automatic t_result table_op_outcome(t_op op, logic [PAGE_W-1:0] page,
                                                 logic granted);
        t_result outcome;
        int      hit;
        int      vacant;
        outcome        = '0;
        outcome.status = ST_OK;
        hit            = -1;
        vacant         = -1;
        if (op != OP_CLEAR) begin
            for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
                if (slot_live[i] && slot_page[i] == page) hit = i;
            end
        end
        outcome.page_present = (hit >= 0);
        case (op)
            OP_SWAP_OUT: begin
                if (!store_ready) begin
                    outcome.status = ST_NOT_READY;
                end else if (hit >= 0) begin
                    outcome.slot_index = SLOT_OUT_W'(hit);
                end else begin
                    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
                        if (!slot_live[i]) vacant = i;
                    end
                    if (vacant < 0) begin
                        outcome.status = ST_FULL;
                    end else begin
                        slot_page[vacant]  = page;
                        slot_live[vacant]  = 1'b1;
                        occupancy          = occupancy + 1'b1;
                        outcome.slot_index = SLOT_OUT_W'(vacant);
                    end
                end
            end
            OP_SWAP_IN: begin
                if (!store_ready) begin
                    outcome.status = ST_NOT_READY;
                end else if (hit < 0) begin
                    outcome.status = ST_NOT_FOUND;
                end else begin
                    outcome.slot_index = SLOT_OUT_W'(hit);
                    if (!granted) begin
                        outcome.status = ST_NO_FRAME;
                    end else begin
                        slot_live[hit] = 1'b0;
                        if (occupancy != 0) occupancy = occupancy - 1'b1;
                    end
                end
            end
            OP_QUERY: begin
                if (hit >= 0) outcome.slot_index = SLOT_OUT_W'(hit);
            end
            default: begin
                for (int i = 0; i < SLOT_COUNT; i++) slot_live[i] = 1'b0;
                occupancy = '0;
            end
        endcase
        outcome.slots_in_use = occupancy;
        return outcome;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result observed;
        t_result predicted;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) slot_live[i] = 1'b0;
            occupancy   = '0;
            store_ready = 1'b0;
            awaited_replies.delete();
        end else begin
            if (i_cfg_we) store_ready = i_cfg_wdata;
            if (i_m_tvalid && i_m_tready) begin
                observed = i_m_tdata[$bits(t_result)-1:0];
                if (awaited_replies.size() == 0) begin
                    $error("reply with no request waiting: %h", i_m_tdata);
                    mismatches++;
                end else begin
                    predicted = awaited_replies.pop_front();
                    if (predicted.status == ST_FULL) full_hits++;
                    check_field("status", 8'(predicted.status), 8'(observed.status));
                    check_field("slot_index", 8'(predicted.slot_index),
                                8'(observed.slot_index));
                    check_field("page_present", 8'(predicted.page_present),
                                8'(observed.page_present));
                    check_field("slots_in_use", 8'(predicted.slots_in_use),
                                8'(observed.slots_in_use));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited_replies.push_back(table_op_outcome(t_op'(i_s_tuser),
                                                           i_s_tdata[PAGE_W-1:0],
                                                           i_s_tdata[PAGE_W]));
            end
        end
        o_pending    <= awaited_replies.size();
        o_fail_count <= mismatches;
        o_full_hits  <= full_hits;
    end

endmodule

FILE: dv/tb_swap_slot_table_top.sv
`timescale 1ns / 100ps
// testbench top for swap_slot_table_top: directed and random swap requests under
// several enable settings, random stalls on both sides; depends on sst_pkg and sst_checker
module tb_swap_slot_table_top;
    import sst_pkg::*;

    localparam int SLOT_COUNT     = 16;
    localparam int REPLY_LATENCY  = SLOT_COUNT + 3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int POOL_DEPTH     = 40;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_wdata = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic                 calm      = 1'b0;
    logic [PAGE_W-1:0]    page_pool [POOL_DEPTH];
    int                   idle_cycles = 0;
    int                   sent = 0;
    int                   cfg_writes = 0;
    int                   fail_count;
    int                   pending;
    int                   full_hits;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    swap_slot_table_top #(
        .SLOT_COUNT(SLOT_COUNT)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    sst_checker #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_full_hits (full_hits)
    );

    always @(posedge clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 7);
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // returns at the edge where the transaction is taken, tvalid still high
    task automatic issue_request(t_op op, logic [PAGE_W-1:0] page, logic granted);
        while (!calm && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - PAGE_W - 1){1'b0}}, granted, page};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_store_ready(logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    task automatic run_random_phase(logic enable, int count, int pool_size, int clear_pct,
                                    int calm_from, int calm_to);
        int                pick;
        t_op               op;
        logic [PAGE_W-1:0] page;
        wait_for_replies();
        set_store_ready(enable);
        page_pool[0] = '0;
        page_pool[1] = '1;
        for (int i = 2; i < POOL_DEPTH; i++) page_pool[i] = PAGE_W'($urandom());
        for (int n = 0; n < count; n++) begin
            calm <= (n >= calm_from) && (n < calm_to);
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                op = OP_SWAP_OUT;
            end else if (pick < 77) begin
                op = OP_SWAP_IN;
            end else if (pick >= 100 - clear_pct) begin
                op = OP_CLEAR;
            end else begin
                op = OP_QUERY;
            end
            if ($urandom_range(0, 9) == 0) begin
                page = PAGE_W'($urandom());
            end else begin
                page = page_pool[$urandom_range(0, pool_size - 1)];
            end
            issue_request(op, page, $urandom_range(0, 99) < 85);
            // hold off until the table has answered everything
            if (n == count / 2) wait_for_replies();
        end
        calm <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // store not ready
        issue_request(OP_SWAP_OUT, 20'h00000, 1'b1);
        issue_request(OP_SWAP_IN, 20'h00000, 1'b1);
        issue_request(OP_QUERY, 20'hFFFFF, 1'b0);
        issue_request(OP_CLEAR, 20'hFFFFF, 1'b1);
        wait_for_replies();
        set_store_ready(1'b1);

        issue_request(OP_SWAP_OUT, 20'h00000, 1'b0);
        issue_request(OP_SWAP_OUT, 20'hFFFFF, 1'b1);
        issue_request(OP_SWAP_OUT, 20'hFFFFF, 1'b0);
        issue_request(OP_QUERY, 20'hFFFFF, 1'b1);
        issue_request(OP_QUERY, 20'h12345, 1'b0);
        issue_request(OP_SWAP_IN, 20'hFFFFF, 1'b0);
        issue_request(OP_SWAP_IN, 20'hFFFFF, 1'b1);
        issue_request(OP_SWAP_IN, 20'hFFFFF, 1'b1);
        issue_request(OP_SWAP_OUT, 20'hABCDE, 1'b1);
        issue_request(OP_CLEAR, 20'h00000, 1'b0);
        issue_request(OP_QUERY, 20'h00000, 1'b1);
        issue_request(OP_SWAP_IN, 20'h00000, 1'b1);

        run_random_phase(1'b1, 233, 20, 4, 0, 0);
        run_random_phase(1'b0, 100, 20, 4, 0, 0);
        run_random_phase(1'b1, 233, 40, 3, 60, 180);
        run_random_phase(1'b1, 233, 18, 1, 0, 0);

        wait_for_replies();
        repeat (REPLY_LATENCY) @(posedge clk);
        $display("run covered %0d transactions across %0d enable writes", sent, cfg_writes);
        $display("%0d replies reported a full table", full_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
